// ===== rtl/core/bdlp_pkg.sv =====
// Shared types and constants for the button debounce / long press block.
// No dependencies.
package bdlp_pkg;

	localparam int NUM_BTN = 3;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int EV_W    = 3;
	localparam int IDX_W   = 2;

	localparam logic [EV_W-1:0] EV_NONE         = 3'd0;
	localparam logic [EV_W-1:0] EV_ACTION_SHORT = 3'd1;
	localparam logic [EV_W-1:0] EV_CANCEL_SHORT = 3'd2;
	localparam logic [EV_W-1:0] EV_MODE_SHORT   = 3'd3;
	localparam logic [EV_W-1:0] EV_ACTION_LONG  = 3'd4;

	localparam logic [IDX_W-1:0] REG_ENABLE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd1;
	localparam logic [IDX_W-1:0] REG_LONG     = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

	// What one lane found for the current poll.
	typedef struct packed {
		logic settled;     // raw level stable for the debounce time
		logic short_ev;    // stable release of a pending press, not suppressed
		logic press_edge;  // stable press edge
		logic sp_n;        // next stable_pressed
		logic pp_n;        // next press_pending
	} lane_res_t;

endpackage

// ===== rtl/core/bdlp_lane.sv =====
// One button lane: raw level tracking, settle timer and stable edge detection.
// Depends on bdlp_pkg. State is committed only when the merge stage allows it.
module bdlp_lane import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              level,
	input  logic [CFG_W-1:0]  debounce_ms,
	input  logic              long_sup,
	input  logic              commit,
	output lane_res_t         res
);

	logic              last_level_q;
	logic              stable_q;
	logic              pending_q;
	logic [TIME_W-1:0] change_q;

	logic              chg;
	logic [TIME_W-1:0] change_n;
	logic [TIME_W-1:0] elapsed;
	logic              settled;
	logic              pressed;
	logic              rel_edge;

	always_comb begin
		chg      = (level != last_level_q);
		change_n = chg ? now_ms : change_q;
		elapsed  = chg ? '0 : (now_ms - change_q);
		settled  = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
		pressed  = ~level;
		res.settled    = settled;
		res.press_edge = settled && pressed && !stable_q;
		rel_edge       = settled && !pressed && stable_q;
		res.short_ev   = rel_edge && pending_q && !long_sup;
		res.sp_n       = res.press_edge ? 1'b1 : (rel_edge ? 1'b0 : stable_q);
		res.pp_n       = res.press_edge ? 1'b1 : (rel_edge ? 1'b0 : pending_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			stable_q     <= 1'b0;
			pending_q    <= 1'b0;
			change_q     <= '0;
		end else if (commit) begin
			last_level_q <= level;
			stable_q     <= res.sp_n;
			pending_q    <= res.pp_n;
			change_q     <= change_n;
		end
	end

endmodule

// ===== rtl/core/bdlp_long.sv =====
// Long-press tracker for the action button: hold start time and reported flag.
// Depends on bdlp_pkg. Fed by the action lane's result.
module bdlp_long import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [CFG_W-1:0]  long_press_ms,
	input  lane_res_t         act,
	input  logic              commit,
	output logic              long_reported,
	output logic              long_ev
);

	logic [TIME_W-1:0] start_q;
	logic              reported_q;
	logic [TIME_W-1:0] start_n;
	logic              reported_n;
	logic [TIME_W-1:0] held;

	always_comb begin
		start_n    = act.press_edge ? now_ms : start_q;
		reported_n = act.press_edge ? 1'b0 : reported_q;
		held       = act.press_edge ? '0 : (now_ms - start_q);
		long_ev    = act.settled && act.sp_n && act.pp_n && !reported_n &&
			(held >= {{(TIME_W-CFG_W){1'b0}}, long_press_ms});
	end

	assign long_reported = reported_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			reported_q <= 1'b0;
		end else if (commit) begin
			start_q    <= start_n;
			reported_q <= reported_n | long_ev;
		end
	end

endmodule

// ===== rtl/core/bdlp_merge.sv =====
// Merge stage: picks the first lane with an event and limits the state commit
// to that lane and the ones before it. Depends on bdlp_pkg.
module bdlp_merge import bdlp_pkg::*; (
	input  logic               go,
	input  lane_res_t          lane_res [NUM_BTN],
	input  logic               long_ev,
	output logic [NUM_BTN-1:0] commit,
	output logic [EV_W-1:0]    event_code
);

	logic ev0;
	logic ev1;

	always_comb begin
		ev0       = lane_res[0].short_ev || long_ev;
		ev1       = lane_res[1].short_ev;
		commit[0] = go;
		commit[1] = go && !ev0;
		commit[2] = go && !ev0 && !ev1;
		if (!go) begin
			event_code = EV_NONE;
		end else if (lane_res[0].short_ev) begin
			event_code = EV_ACTION_SHORT;
		end else if (long_ev) begin
			event_code = EV_ACTION_LONG;
		end else if (ev1) begin
			event_code = EV_CANCEL_SHORT;
		end else if (lane_res[2].short_ev) begin
			event_code = EV_MODE_SHORT;
		end else begin
			event_code = EV_NONE;
		end
	end

endmodule

// ===== rtl/core/button_debounce_long_press_top.sv =====
// Top level of the three-button debouncer with action long-press detection.
// Depends on bdlp_pkg, bdlp_lane, bdlp_long and bdlp_merge.
//
// Usage:
//   Poll channel (in_valid/in_stall): now_ms plus raw active-low levels of the
//   action, cancel and mode buttons. A transaction happens when in_valid is
//   high and in_stall is low.
//   Result channel (out_valid/out_stall): one event_res per poll, in order.
//   0 none, 1 action short, 2 cancel short, 3 mode short, 4 action long.
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 enable, 1 debounce_ms,
//   2 long_press_ms. cfg_ready is always high; write only while idle.
//   Result: registered, valid in the cycle after the poll transaction.
//   Throughput: one poll per cycle while in_stall is low; three lanes evaluate all buttons in
//   parallel and the merge stage resolves the first event in that same cycle.
//   Stall: the output register holds its result while out_stall is high and
//   in_stall follows, so no new poll is taken until the result leaves.
//   Reset: disabled, debounce 50 ms, long press 1000 ms, all buttons released.
module button_debounce_long_press_top import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              action_level,
	input  logic              cancel_level,
	input  logic              mode_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [EV_W-1:0]   event_res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic               enable_q;
	logic [CFG_W-1:0]   debounce_q;
	logic [CFG_W-1:0]   long_q;
	logic               out_valid_q;
	logic [EV_W-1:0]    event_q;

	logic               accept;
	logic               go;
	logic [NUM_BTN-1:0] levels;
	logic [NUM_BTN-1:0] long_sup;
	logic [NUM_BTN-1:0] commit;
	lane_res_t          lane_res [NUM_BTN];
	logic               long_reported;
	logic               long_ev;
	logic [EV_W-1:0]    event_code;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign go        = accept && enable_q;
	assign levels    = {mode_level, cancel_level, action_level};
	assign long_sup  = {2'b00, long_reported};
	assign out_valid = out_valid_q;
	assign event_res = event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_LONG:     long_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_BTN; gi++) begin : g_lane
			bdlp_lane u_lane (
				.clk         (clk),
				.arst_n      (arst_n),
				.now_ms      (now_ms),
				.level       (levels[gi]),
				.debounce_ms (debounce_q),
				.long_sup    (long_sup[gi]),
				.commit      (commit[gi]),
				.res         (lane_res[gi])
			);
		end
	endgenerate

	bdlp_long u_long (
		.clk           (clk),
		.arst_n        (arst_n),
		.now_ms        (now_ms),
		.long_press_ms (long_q),
		.act           (lane_res[0]),
		.commit        (commit[0]),
		.long_reported (long_reported),
		.long_ev       (long_ev)
	);

	bdlp_merge u_merge (
		.go         (go),
		.lane_res   (lane_res),
		.long_ev    (long_ev),
		.commit     (commit),
		.event_code (event_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			event_q <= event_code;
		end
	end

	a_commit_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		commit[2] |-> (commit[1] && commit[0]))
		else $error("lane commit is not a prefix");

	a_disabled_none: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !enable_q) |=> (event_res == EV_NONE))
		else $error("event reported while disabled");

	a_long_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(long_reported) |-> ($past(long_ev) && $past(commit[0])))
		else $error("long press flag set without a long event");

	a_short_before_long: assert property (@(posedge clk) disable iff (!arst_n)
		!(lane_res[0].short_ev && long_ev))
		else $error("action short and long event in one poll");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for button_debounce_long_press_top: directed and random polls,
// checked against a behavioral debounce/long-press predictor.
// Depends on bdlp_pkg and the block's RTL.
module tb_top;
	import bdlp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [EV_W-1:0] SHORT_EV [NUM_BTN] =
		'{EV_ACTION_SHORT, EV_CANCEL_SHORT, EV_MODE_SHORT};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [TIME_W-1:0] now_ms       = '0;
	logic              action_level = 1'b1;
	logic              cancel_level = 1'b1;
	logic              mode_level   = 1'b1;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [EV_W-1:0]   event_res;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_W-1:0]  cfg_data     = '0;

	// predictor copy of registers and button state
	logic              en_set;
	logic [CFG_W-1:0]  debounce_set;
	logic [CFG_W-1:0]  long_set;
	logic              raw_lvl    [NUM_BTN];
	logic              stable_prs [NUM_BTN];
	logic              pend_prs   [NUM_BTN];
	logic [TIME_W-1:0] chg_ms     [NUM_BTN];
	logic [TIME_W-1:0] hold_ms;
	logic              long_seen;

	logic [EV_W-1:0]   events_due [$];
	logic [EV_W-1:0]   exp_ev;
	int                errors    = 0;
	int                cycle_cnt = 0;
	bit                gaps_on   = 1'b1;
	bit                stall_on  = 1'b1;
	logic [TIME_W-1:0] t_ms      = '0;
	logic [2:0]        lv_held   = 3'b111;

	button_debounce_long_press_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.action_level (action_level),
		.cancel_level (cancel_level),
		.mode_level   (mode_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= stall_on && ($urandom_range(99) < 6);
	end

	// outputs are stable from the falling edge to the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (events_due.size() == 0) begin
				errors++;
				$display("%0t: event_res expected none, actual %0d", $time, event_res);
			end else begin
				exp_ev = events_due.pop_front();
				if (event_res !== exp_ev) begin
					errors++;
					$display("%0t: event_res expected %0d, actual %0d",
						$time, exp_ev, event_res);
				end
			end
		end
	end

	function automatic void clear_buttons();
		en_set       = 1'b0;
		debounce_set = DEBOUNCE_RST;
		long_set     = LONG_RST;
		for (int b = 0; b < NUM_BTN; b++) begin
			raw_lvl[b]    = 1'b1;
			stable_prs[b] = 1'b0;
			pend_prs[b]   = 1'b0;
			chg_ms[b]     = '0;
		end
		hold_ms   = '0;
		long_seen = 1'b0;
	endfunction

	// lv[0] action, lv[1] cancel, lv[2] mode; 0 means pressed
	function automatic logic [EV_W-1:0] poll_event(input logic [TIME_W-1:0] t,
		input logic [2:0] lv);
		logic [EV_W-1:0]   ev;
		logic [TIME_W-1:0] dt;
		logic              pressed;
		logic              done;
		ev   = EV_NONE;
		done = !en_set;
		for (int b = 0; b < NUM_BTN; b++) begin
			if (!done) begin
				if (lv[b] != raw_lvl[b])
					chg_ms[b] = t;
				raw_lvl[b] = lv[b];
				dt = t - chg_ms[b];
				if (dt >= TIME_W'(debounce_set)) begin
					pressed = !lv[b];
					if (pressed && !stable_prs[b]) begin
						stable_prs[b] = 1'b1;
						pend_prs[b]   = 1'b1;
						if (b == 0) begin
							hold_ms   = t;
							long_seen = 1'b0;
						end
					end
					if (!pressed && stable_prs[b]) begin
						stable_prs[b] = 1'b0;
						if (pend_prs[b] && !(b == 0 && long_seen)) begin
							ev   = SHORT_EV[b];
							done = 1'b1;
						end
						pend_prs[b] = 1'b0;
					end
					if (!done && b == 0 && stable_prs[0] && pend_prs[0] && !long_seen) begin
						dt = t - hold_ms;
						if (dt >= TIME_W'(long_set)) begin
							long_seen = 1'b1;
							ev        = EV_ACTION_LONG;
							done      = 1'b1;
						end
					end
				end
			end
		end
		return ev;
	endfunction

	task automatic send_poll(input logic [TIME_W-1:0] t, input logic [2:0] lv);
		if (gaps_on && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		now_ms       <= t;
		action_level <= lv[0];
		cancel_level <= lv[1];
		mode_level   <= lv[2];
		@(negedge clk);
		while (in_stall) @(negedge clk);
		events_due.push_back(poll_event(t, lv));
		@(posedge clk);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			REG_ENABLE:   en_set       = val[0];
			REG_DEBOUNCE: debounce_set = val;
			REG_LONG:     long_set     = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold);
		wait_results();
		set_reg(REG_DEBOUNCE, deb);
		set_reg(REG_LONG, hold);
	endtask

	task automatic random_polls(input int n);
		int         r;
		int         stride;
		logic [2:0] lv;
		stride = int'(debounce_set) + int'(long_set) + 2;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3)
				t_ms = $urandom;
			else if (r >= 15 && r < 55)
				t_ms = t_ms + $urandom_range(1, 20);
			else if (r >= 55)
				t_ms = t_ms + $urandom_range(1, stride);
			if ($urandom_range(99) < 8) begin
				lv = 3'($urandom_range(7));
			end else begin
				for (int b = 0; b < NUM_BTN; b++)
					if ($urandom_range(99) < 12)
						lv_held[b] = ~lv_held[b];
				lv = lv_held;
			end
			send_poll(t_ms, lv);
		end
	endtask

	task automatic test_disabled_after_reset();
		send_poll(32'd10, 3'b000);
		send_poll(32'd70, 3'b000);
		wait_results();
		set_reg(REG_ENABLE, 16'd1);
		set_reg(REG_DEBOUNCE, 16'd50);
		set_reg(REG_LONG, 16'd1000);
	endtask

	task automatic test_short_press();
		send_poll(32'd100, 3'b110);
		send_poll(32'd160, 3'b110);
		send_poll(32'd200, 3'b111);
		send_poll(32'd260, 3'b111);
		// cancel and mode released together: cancel wins, mode follows
		send_poll(32'd300, 3'b001);
		send_poll(32'd360, 3'b001);
		send_poll(32'd400, 3'b111);
		send_poll(32'd460, 3'b111);
		send_poll(32'd461, 3'b111);
	endtask

	task automatic test_long_press();
		send_poll(32'd1000, 3'b110);
		send_poll(32'd1060, 3'b110);
		send_poll(32'd2060, 3'b110);
		send_poll(32'd2100, 3'b111);
		send_poll(32'd2160, 3'b111);
	endtask

	task automatic test_zero_timing();
		set_timing(16'd0, 16'd0);
		send_poll(32'd3000, 3'b110);
		send_poll(32'd3001, 3'b111);
		send_poll(32'd3002, 3'b101);
		send_poll(32'd3003, 3'b111);
	endtask

	task automatic test_time_wrap();
		set_timing(16'd50, 16'd1000);
		send_poll(32'hFFFF_FFE0, 3'b110);
		send_poll(32'hFFFF_FFFF, 3'b110);
		send_poll(32'h0000_0020, 3'b110);
		send_poll(32'h0000_0040, 3'b111);
		send_poll(32'h0000_0080, 3'b111);
		t_ms = 32'h0000_0080;
	endtask

	task automatic test_random_default();
		random_polls(100);
	endtask

	task automatic test_random_extremes();
		set_timing(16'd0, 16'd0);
		random_polls(40);
		set_timing(16'hFFFF, 16'hFFFF);
		random_polls(40);
	endtask

	task automatic test_random_disabled();
		wait_results();
		set_reg(REG_ENABLE, 16'd0);
		set_reg(REG_SPARE, CFG_W'($urandom));
		random_polls(30);
		wait_results();
		set_reg(REG_ENABLE, 16'd1);
		random_polls(20);
	endtask

	task automatic test_random_steady();
		set_timing(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 3000)));
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		random_polls(100);
		gaps_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_random_wrap();
		set_timing(CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(100, 5000)));
		t_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
		random_polls(70);
		set_timing(CFG_W'($urandom), CFG_W'($urandom));
		random_polls(50);
	endtask

	initial begin
		clear_buttons();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_after_reset();
		test_short_press();
		test_long_press();
		test_zero_timing();
		test_time_wrap();
		test_random_default();
		test_random_extremes();
		test_random_disabled();
		test_random_steady();
		test_random_wrap();
		wait_results();
		repeat (5) @(posedge clk);
		if (errors == 0 && events_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_lane.sv
rtl/core/bdlp_long.sv
rtl/core/bdlp_merge.sv
rtl/core/button_debounce_long_press_top.sv
bench/tb_top.sv
